// ===== hw/rtl/lssc_pkg.sv =====
// Shared types, constants and helpers of the line segment screen clipper.
// Used by every module of the block; no dependencies.
`default_nettype none

package lssc_pkg;

   // Fixed-point format and screen limits
   localparam int FRAC_BITS   = 8;
   localparam int SCREEN_BITS = 12;
   localparam int IN_W        = 24;
   localparam int OUT_W       = 21;
   localparam int SIZE_W      = 13;
   localparam int CSR_IDX_W   = 4;

   // Internal coordinate width. A far-edge interpolation can overshoot the
   // span by up to (1 + 2^FRAC_BITS / min span), so x-pass results on the
   // other axis grow to about 34 bits; 36 bits covers that with margin.
   localparam int CW       = 36;
   localparam int MW       = CW;       // magnitude width of span and numerator
   localparam int PW       = 2 * MW;   // product width
   localparam int PP_SPLIT = 18;       // low slice of the split multiplier
   localparam int QW       = 34;       // quotient bits, one per divider stage

   // Span counts as zero when span * 1000 < 2^FRAC_BITS
   localparam int ZS_LIM = (2 ** FRAC_BITS + 999) / 1000;

   localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);
   localparam logic [SIZE_W-1:0] SIZE_MAX     = SIZE_W'(2 ** SCREEN_BITS);
   localparam logic [SIZE_W-1:0] SIZE_MIN     = SIZE_W'(1);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SCREEN_HEIGHT = CSR_IDX_W'(1);

   // Axis selectors
   localparam int AXIS_X = 0;
   localparam int AXIS_Y = 1;

   typedef struct packed {
      logic signed [IN_W-1:0] start_x;
      logic signed [IN_W-1:0] start_y;
      logic signed [IN_W-1:0] end_x;
      logic signed [IN_W-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic             visible;
      logic [OUT_W-1:0] out_start_x;
      logic [OUT_W-1:0] out_start_y;
      logic [OUT_W-1:0] out_end_x;
      logic [OUT_W-1:0] out_end_y;
   } rsp_type;

   // One segment in flight; p and q indexed by axis, read as signed
   typedef struct packed {
      logic                  alive;
      logic [1:0][CW-1:0]    p;
      logic [1:0][CW-1:0]    q;
   } item_type;

   // size << FRAC_BITS
   function automatic logic signed [CW-1:0] full_of(input logic [SIZE_W-1:0] size);
      full_of = $signed(CW'(size) << FRAC_BITS);
   endfunction

   // (size - 1) << FRAC_BITS
   function automatic logic signed [CW-1:0] edge_of(input logic [SIZE_W-1:0] size);
      edge_of = $signed(CW'(size - SIZE_MIN) << FRAC_BITS);
   endfunction

   // Bring a written size into [1, 2^SCREEN_BITS]
   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      r = v;
      if (r < SIZE_MIN) r = SIZE_MIN;
      if (r > SIZE_MAX) r = SIZE_MAX;
      clamp_size = r;
   endfunction

   // Clamp a coordinate to [0, size << FRAC_BITS]
   function automatic logic [OUT_W-1:0] clamp_out(input logic [CW-1:0] v,
                                                 input logic [SIZE_W-1:0] size);
      logic signed [CW-1:0] full;
      logic signed [CW-1:0] r;
      full = full_of(size);
      r = $signed(v);
      if (r < 0) r = '0;
      if (r > full) r = full;
      clamp_out = OUT_W'(r);
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lssc_sort.sv =====
// One-stage endpoint ordering and trivial reject along one axis.
// Depends on lssc_pkg.
`default_nettype none

module lssc_sort #(
   parameter int AXIS = lssc_pkg::AXIS_X
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        adv,
   input  wire logic                        in_valid,
   input  wire lssc_pkg::item_type          in_item,
   input  wire logic [lssc_pkg::SIZE_W-1:0] size,
   output logic                             out_valid,
   output lssc_pkg::item_type               out_item
);

   logic                 valid_ff;
   lssc_pkg::item_type   item_ff;
   lssc_pkg::item_type   item_in;
   logic signed [lssc_pkg::CW-1:0] pa;
   logic signed [lssc_pkg::CW-1:0] qa;
   logic signed [lssc_pkg::CW-1:0] full;

   // Order by this axis, then reject when wholly before or past the screen
   always_comb begin
      full    = lssc_pkg::full_of(size);
      item_in = in_item;
      if ($signed(in_item.p[AXIS]) > $signed(in_item.q[AXIS])) begin
         item_in.p = in_item.q;
         item_in.q = in_item.p;
      end
      pa = $signed(item_in.p[AXIS]);
      qa = $signed(item_in.q[AXIS]);
      if (qa < 0 || pa > full) item_in.alive = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lssc_interp.sv =====
// Pipelined endpoint move along one axis: split multiplier, restoring
// divider with one quotient bit per stage, then the update. Uses lssc_pkg.
`default_nettype none

module lssc_interp #(
   parameter int AXIS     = lssc_pkg::AXIS_X,
   parameter bit MOVE_END = 1'b0
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        adv,
   input  wire logic                        in_valid,
   input  wire lssc_pkg::item_type          in_item,
   input  wire logic [lssc_pkg::SIZE_W-1:0] size,
   output logic                             out_valid,
   output lssc_pkg::item_type               out_item
);

   localparam int MW    = lssc_pkg::MW;
   localparam int CW    = lssc_pkg::CW;
   localparam int PW    = lssc_pkg::PW;
   localparam int QW    = lssc_pkg::QW;
   localparam int SPL   = lssc_pkg::PP_SPLIT;
   localparam int OTHER = 1 - AXIS;

   typedef struct packed {
      lssc_pkg::item_type item;
      logic               need;
      logic               neg;
      logic [MW-1:0]      d;
      logic [MW-1:0]      m;
      logic [MW-1:0]      dcmag;
   } setup_type;

   typedef struct packed {
      lssc_pkg::item_type item;
      logic               need;
      logic               neg;
      logic [MW-1:0]      d;
      logic [SPL+MW-1:0]  pp_lo;
      logic [PW-SPL-1:0]  pp_hi;
   } mul_type;

   typedef struct packed {
      lssc_pkg::item_type item;
      logic               need;
      logic               neg;
      logic [MW-1:0]      d;
      logic [MW:0]        rem;
      logic [QW-1:0]      num;   // low dividend bits, quotient shifts in
   } div_type;

   // One restoring division step
   function automatic div_type div_step(input div_type s);
      div_type       r;
      logic [MW:0]   t;
      logic          qb;
      r  = s;
      t  = {s.rem[MW-1:0], s.num[QW-1]};
      qb = (t >= {1'b0, s.d});
      if (qb) t = t - {1'b0, s.d};
      r.rem = t;
      r.num = {s.num[QW-2:0], qb};
      div_step = r;
   endfunction

   logic                   s1_valid_ff;
   setup_type              s1_ff;
   setup_type              s1_in;
   logic                   s2_valid_ff;
   mul_type                s2_ff;
   mul_type                s2_in;
   logic [QW:0]            dv_valid_ff;
   div_type                div_ff [QW+1];
   div_type                div_in [QW+1];
   logic                   out_valid_ff;
   lssc_pkg::item_type     out_ff;
   lssc_pkg::item_type     out_in;

   logic signed [CW-1:0]   pa, qa, pb, qb_c, dc, full, edge_c, sq;
   logic [PW-1:0]          prod;

   // Setup: decide whether this endpoint moves, and the division operands
   always_comb begin
      full   = lssc_pkg::full_of(size);
      edge_c = lssc_pkg::edge_of(size);
      pa     = $signed(in_item.p[AXIS]);
      qa     = $signed(in_item.q[AXIS]);
      pb     = $signed(in_item.p[OTHER]);
      qb_c   = $signed(in_item.q[OTHER]);
      dc     = qb_c - pb;
      s1_in.item  = in_item;
      s1_in.need  = in_item.alive && (MOVE_END ? (qa >= full) : (pa < 0));
      s1_in.d     = MW'(qa - pa);
      s1_in.m     = MOVE_END ? MW'(qa - edge_c) : MW'(-pa);
      s1_in.dcmag = dc[CW-1] ? MW'(-dc) : MW'(dc);
      s1_in.neg   = dc[CW-1] ^ MOVE_END;
      // zero span on a needed move rejects the segment
      if (s1_in.need && (s1_in.d < MW'(lssc_pkg::ZS_LIM))) begin
         s1_in.item.alive = 1'b0;
         s1_in.need       = 1'b0;
      end
   end

   // Partial products of the split multiplier
   always_comb begin
      s2_in.item  = s1_ff.item;
      s2_in.need  = s1_ff.need;
      s2_in.neg   = s1_ff.neg;
      s2_in.d     = s1_ff.d;
      s2_in.pp_lo = (SPL+MW)'(s1_ff.m[SPL-1:0]) * (SPL+MW)'(s1_ff.dcmag);
      s2_in.pp_hi = (PW-SPL)'(s1_ff.m[MW-1:SPL]) * (PW-SPL)'(s1_ff.dcmag);
   end

   // Sum the products and load the divider; then one bit per stage
   always_comb begin
      prod = (PW'(s2_ff.pp_hi) << SPL) + PW'(s2_ff.pp_lo);
      div_in[0].item = s2_ff.item;
      div_in[0].need = s2_ff.need;
      div_in[0].neg  = s2_ff.neg;
      div_in[0].d    = s2_ff.d;
      div_in[0].rem  = (MW+1)'(prod >> QW);
      div_in[0].num  = prod[QW-1:0];
      for (int k = 0; k < QW; k++) begin
         div_in[k+1] = div_step(div_ff[k]);
      end
   end

   // Apply the truncated quotient and pin the moved coordinate to the edge
   always_comb begin
      sq     = div_ff[QW].neg ? -$signed(CW'(div_ff[QW].num))
                              :  $signed(CW'(div_ff[QW].num));
      out_in = div_ff[QW].item;
      if (div_ff[QW].need) begin
         if (MOVE_END) begin
            out_in.q[OTHER] = CW'($signed(div_ff[QW].item.q[OTHER]) + sq);
            out_in.q[AXIS]  = CW'(lssc_pkg::edge_of(size));
         end else begin
            out_in.p[OTHER] = CW'($signed(div_ff[QW].item.p[OTHER]) + sq);
            out_in.p[AXIS]  = '0;
         end
      end
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         dv_valid_ff  <= '0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= in_valid;
         s2_valid_ff  <= s1_valid_ff;
         dv_valid_ff  <= {dv_valid_ff[QW-1:0], s2_valid_ff};
         out_valid_ff <= dv_valid_ff[QW];
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         for (int k = 0; k <= QW; k++) begin
            div_ff[k] <= div_in[k];
         end
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/line_segment_screen_clipper_core.sv =====
// Top level of the line segment screen clipper: config registers, the
// x and y clip passes, and the output register. Uses lssc_pkg, lssc_sort
// and lssc_interp.
//
// Clips one segment (signed fixed point, 8 fraction bits) to a screen of
// screen_width by screen_height pixels and returns a visible flag and the
// clipped endpoints, all zero when rejected. One item is accepted every
// cycle; the pipeline has one ordering stage per axis, four endpoint
// interpolators of 38 stages each (two for the split multiply, 34 for the
// one-bit-per-stage divider, one each to set up and apply), and the output
// register. A stall on the result side holds the whole pipeline. The user
// must write sizes through the csr port only while no item is in flight;
// the block does not enforce it. 0 reads as 1 and values above 4096 as 4096.
`default_nettype none

module line_segment_screen_clipper_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire lssc_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output lssc_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [lssc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [lssc_pkg::SIZE_W-1:0]    csr_wdata
);

   localparam int CW   = lssc_pkg::CW;
   localparam int IN_W = lssc_pkg::IN_W;

   logic [lssc_pkg::SIZE_W-1:0] width_ff, width_in;
   logic [lssc_pkg::SIZE_W-1:0] height_ff, height_in;
   logic                        adv;
   lssc_pkg::item_type          entry;
   logic                        rsp_valid_ff;
   lssc_pkg::rsp_type           rsp_ff, rsp_in;

   logic               v_sx, v_xp, v_xq, v_sy, v_yp, v_yq;
   lssc_pkg::item_type i_sx, i_xp, i_xq, i_sy, i_yp, i_yq;

   // Config registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            lssc_pkg::REG_SCREEN_WIDTH:  width_in  = lssc_pkg::clamp_size(csr_wdata);
            lssc_pkg::REG_SCREEN_HEIGHT: height_in = lssc_pkg::clamp_size(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lssc_pkg::WIDTH_RESET;
         height_ff <= lssc_pkg::HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign csr_ready = 1'b1;

   // Whole pipeline moves when the output register is free or being read
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // Sign-extend the incoming endpoints
   always_comb begin
      entry.alive = 1'b1;
      entry.p[lssc_pkg::AXIS_X] = {{(CW-IN_W){req_data.start_x[IN_W-1]}}, req_data.start_x};
      entry.p[lssc_pkg::AXIS_Y] = {{(CW-IN_W){req_data.start_y[IN_W-1]}}, req_data.start_y};
      entry.q[lssc_pkg::AXIS_X] = {{(CW-IN_W){req_data.end_x[IN_W-1]}}, req_data.end_x};
      entry.q[lssc_pkg::AXIS_Y] = {{(CW-IN_W){req_data.end_y[IN_W-1]}}, req_data.end_y};
   end

   // X pass
   lssc_sort #(.AXIS(lssc_pkg::AXIS_X)) u_sort_x (
      .clock, .reset, .adv, .in_valid(req_valid), .in_item(entry), .size(width_ff),
      .out_valid(v_sx), .out_item(i_sx));

   lssc_interp #(.AXIS(lssc_pkg::AXIS_X), .MOVE_END(1'b0)) u_interp_xp (
      .clock, .reset, .adv, .in_valid(v_sx), .in_item(i_sx), .size(width_ff),
      .out_valid(v_xp), .out_item(i_xp));

   lssc_interp #(.AXIS(lssc_pkg::AXIS_X), .MOVE_END(1'b1)) u_interp_xq (
      .clock, .reset, .adv, .in_valid(v_xp), .in_item(i_xp), .size(width_ff),
      .out_valid(v_xq), .out_item(i_xq));

   // Y pass
   lssc_sort #(.AXIS(lssc_pkg::AXIS_Y)) u_sort_y (
      .clock, .reset, .adv, .in_valid(v_xq), .in_item(i_xq), .size(height_ff),
      .out_valid(v_sy), .out_item(i_sy));

   lssc_interp #(.AXIS(lssc_pkg::AXIS_Y), .MOVE_END(1'b0)) u_interp_yp (
      .clock, .reset, .adv, .in_valid(v_sy), .in_item(i_sy), .size(height_ff),
      .out_valid(v_yp), .out_item(i_yp));

   lssc_interp #(.AXIS(lssc_pkg::AXIS_Y), .MOVE_END(1'b1)) u_interp_yq (
      .clock, .reset, .adv, .in_valid(v_yp), .in_item(i_yp), .size(height_ff),
      .out_valid(v_yq), .out_item(i_yq));

   // Final clamp; rejected items come out as all zero
   always_comb begin
      rsp_in = '0;
      if (i_yq.alive) begin
         rsp_in.visible     = 1'b1;
         rsp_in.out_start_x = lssc_pkg::clamp_out(i_yq.p[lssc_pkg::AXIS_X], width_ff);
         rsp_in.out_start_y = lssc_pkg::clamp_out(i_yq.p[lssc_pkg::AXIS_Y], height_ff);
         rsp_in.out_end_x   = lssc_pkg::clamp_out(i_yq.q[lssc_pkg::AXIS_X], width_ff);
         rsp_in.out_end_y   = lssc_pkg::clamp_out(i_yq.q[lssc_pkg::AXIS_Y], height_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v_yq;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // A rejected item carries no coordinates
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.visible |->
         (rsp_data.out_start_x == '0) && (rsp_data.out_start_y == '0) &&
         (rsp_data.out_end_x == '0) && (rsp_data.out_end_y == '0))
      else $error("rejected item with nonzero coordinates");

   // Visible coordinates stay on the clamped screen
   a_on_screen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.visible |->
         (CW'(rsp_data.out_start_x) <= CW'(lssc_pkg::full_of(width_ff))) &&
         (CW'(rsp_data.out_end_x) <= CW'(lssc_pkg::full_of(width_ff))) &&
         (CW'(rsp_data.out_start_y) <= CW'(lssc_pkg::full_of(height_ff))) &&
         (CW'(rsp_data.out_end_y) <= CW'(lssc_pkg::full_of(height_ff))))
      else $error("visible coordinate beyond screen");

   // Stored sizes stay in range
   a_size_range: assert property (@(posedge clock) disable iff (reset)
      (width_ff >= lssc_pkg::SIZE_MIN) && (width_ff <= lssc_pkg::SIZE_MAX) &&
      (height_ff >= lssc_pkg::SIZE_MIN) && (height_ff <= lssc_pkg::SIZE_MAX))
      else $error("screen size register out of range");

   // A stalled result keeps the pipeline frozen, so it is not replaced
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed under stall");

endmodule

`default_nettype wire
